// ===== rtl/ufd_pkg.sv =====
package ufd_pkg;

  // One input beat: raw byte plus end-of-string flag.
  typedef struct packed {
    logic [7:0] char_in;
    logic       string_end;
  } in_beat_t;

  // One output beat.
  typedef struct packed {
    logic [7:0] char_out;
    logic       run_last;
    logic       string_done;
  } out_beat_t;

  localparam int unsigned MaxBytes = 3;

  // Classified work for one input byte: up to three output bytes.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [1:0]               cnt;
    logic                     str_end;
  } entry_t;

endpackage

// ===== rtl/url_percent_decoder_top.sv =====
// Channel | Dir | Handshake          | Beat
// --------+-----+--------------------+-------------------------------------
// in      | in  | in_valid/in_stall  | char_in, string_end (in_beat_t)
// out     | out | out_valid/out_stall| char_out, run_last, string_done
//
// One input byte per cycle when the queue has room; each input yields 0..3
// output beats, and the back end drives one beat per cycle when unstalled.
// An input beat reaches the output through the queue and the output holding
// register. Reset (rst, synchronous) clears the escape state, the
// queue pointers and the output holding register. in_stall rises only when
// the QueueDepth-entry queue is full; out_stall holds the current beat.
module url_percent_decoder_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ufd_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output ufd_pkg::out_beat_t out_beat
);

  logic            accept;
  logic            push;
  ufd_pkg::entry_t push_entry;
  logic            esc_idle;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  ufd_pkg::entry_t q_data;

  // Front accepts whenever the queue can take an entry; inputs that make
  // no output (a bare '%' or first hex digit) only move the escape state.
  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;

  ufd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .beat     (in_beat),
    .push     (push),
    .entry    (push_entry),
    .esc_idle (esc_idle)
  );

  ufd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_data  (push_entry),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  // Back end walks each entry's bytes, one output beat per unstalled cycle.
  ufd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .valid   (out_valid),
    .stall   (out_stall),
    .beat    (out_beat)
  );

  // string_done only ever marks the closing beat of an input
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.string_done |-> out_beat.run_last)
    else $error("string_done without run_last");

  // end of string always leaves the escape state normal
  a_end_flushes: assert property (@(posedge clk) disable iff (rst)
    accept && in_beat.string_end |=> esc_idle)
    else $error("escape pending after end of string");

  // an end-of-string beat always produces output work
  a_end_has_output: assert property (@(posedge clk) disable iff (rst)
    accept && in_beat.string_end |=> (out_valid || q_valid))
    else $error("end of string produced no output");

  // output register starts empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

// ===== rtl/ufd_front.sv =====
module ufd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  ufd_pkg::in_beat_t beat,
  output logic              push,
  output ufd_pkg::entry_t   entry,
  output logic              esc_idle
);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_PCT    = 3'b010,
    MODE_DIGIT  = 3'b100
  } mode_t;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChDel   = 8'h7F;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c <= 8'h46) begin
      d = c - 8'h37;
    end else begin
      d = c - 8'h57;
    end
    hex_val = d[3:0];
  endfunction

  mode_t      mode;
  mode_t      mode_next;
  logic [7:0] digit;
  logic [7:0] digit_next;

  logic [7:0] blist [4];
  logic [1:0] n;
  logic       do_plain;
  logic [7:0] dec;
  logic [7:0] c;

  always_comb begin
    c          = beat.char_in;
    mode_next  = MODE_NORMAL;
    digit_next = digit;
    n          = 2'd0;
    do_plain   = 1'b0;
    dec        = {hex_val(digit), hex_val(c)};
    for (int i = 0; i < 4; i++) begin
      blist[i] = 8'h00;
    end

    case (mode)
      MODE_PCT: begin
        if (is_hex(c)) begin
          digit_next = c;
          mode_next  = MODE_DIGIT;
        end else begin
          blist[n] = ChPct;
          n        = n + 2'd1;
          do_plain = 1'b1;
        end
      end
      MODE_DIGIT: begin
        if (is_hex(c)) begin
          if (dec < ChSpace || dec == ChDel) begin
            dec = ChUnder;
          end
          blist[n] = dec;
          n        = n + 2'd1;
        end else begin
          blist[n] = ChPct;
          n        = n + 2'd1;
          blist[n] = digit;
          n        = n + 2'd1;
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      if (c == ChPlus) begin
        blist[n] = ChSpace;
        n        = n + 2'd1;
      end else if (c == ChPct) begin
        mode_next = MODE_PCT;
      end else begin
        blist[n] = c;
        n        = n + 2'd1;
      end
    end

    // end of string flushes a pending escape literally
    if (beat.string_end) begin
      if (mode_next == MODE_PCT) begin
        blist[n] = ChPct;
        n        = n + 2'd1;
      end else if (mode_next == MODE_DIGIT) begin
        blist[n] = ChPct;
        n        = n + 2'd1;
        blist[n] = digit_next;
        n        = n + 2'd1;
      end
      mode_next = MODE_NORMAL;
    end

    entry.bytes[0] = blist[0];
    entry.bytes[1] = blist[1];
    entry.bytes[2] = blist[2];
    entry.cnt      = n;
    entry.str_end  = beat.string_end;
    push           = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_NORMAL;
      digit <= 8'h00;
    end else if (accept) begin
      mode  <= mode_next;
      digit <= digit_next;
    end
  end

  assign esc_idle = (mode == MODE_NORMAL);

endmodule

// ===== rtl/ufd_fifo.sv =====
module ufd_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  ufd_pkg::entry_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output ufd_pkg::entry_t rd_data
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ufd_pkg::entry_t mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] level;

  logic do_wr;
  logic do_rd;

  assign full     = (level == FullCnt);
  assign rd_valid = (level != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        level <= level + CntW'(1);
      end else if (do_rd && !do_wr) begin
        level <= level - CntW'(1);
      end
    end
  end

endmodule

// ===== rtl/ufd_back.sv =====
module ufd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  ufd_pkg::entry_t    q_data,
  output logic               q_pop,
  output logic               valid,
  input  logic               stall,
  output ufd_pkg::out_beat_t beat
);

  ufd_pkg::entry_t cur;
  logic            held;
  logic [1:0]      idx;
  logic            last;
  logic            sent;

  assign last  = (idx == cur.cnt - 2'd1);
  assign sent  = held && !stall;
  assign q_pop = q_valid && (!held || (sent && last));
  assign valid = held;

  assign beat.char_out    = cur.bytes[idx];
  assign beat.run_last    = last;
  assign beat.string_done = last && cur.str_end;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= 2'd0;
    end else if (q_pop) begin
      held <= 1'b1;
      idx  <= 2'd0;
    end else if (sent) begin
      if (last) begin
        held <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

endmodule

// ===== verif/tb_url_percent_decoder_top.sv =====
module tb_url_percent_decoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Characters the decoder treats specially.
  localparam logic [7:0] CH_PLUS       = "+";
  localparam logic [7:0] CH_PCT        = "%";
  localparam logic [7:0] CH_SPACE      = " ";
  localparam logic [7:0] CH_UNDERSCORE = "_";
  localparam logic [7:0] CH_DEL        = 8'h7F;
  // Decoded bytes below this are control codes and get masked.
  localparam logic [7:0] CTRL_LIMIT    = 8'h20;
  localparam logic [7:0] CH_ZERO       = "0";
  localparam logic [7:0] CH_NINE       = "9";
  localparam logic [7:0] CH_UPPER_A    = "A";
  localparam logic [7:0] CH_UPPER_F    = "F";
  localparam logic [7:0] CH_LOWER_A    = "a";
  localparam logic [7:0] CH_LOWER_F    = "f";

  // Minimum random beats per idle phase; the directed beats come on top of these.
  localparam int unsigned BEATS_PER_PHASE = 48;
  // Extra cycles after the last expected beat, to catch stray output.
  localparam int unsigned DRAIN_CYCLES    = 10;
  // Hard stop; the slowest legal run needs well under a tenth of this.
  localparam int unsigned RUN_LIMIT_NS    = 2_000_000;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,  // plain text
    ESC_PCT   = 2'd1,  // '%' seen
    ESC_DIGIT = 2'd2   // '%' and one hex digit seen
  } esc_state_t;

  // Returns {invalid, value}: bit 4 set when c is no hex digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return {1'b0, 4'(c - CH_ZERO)};
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return {1'b0, 4'(c - CH_UPPER_A + 8'd10)};
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return {1'b0, 4'(c - CH_LOWER_A + 8'd10)};
    return 5'h10;
  endfunction

  // --------------------------------------------------------------------------
  // Decoder prediction and expected-beat store.
  // --------------------------------------------------------------------------
  class decode_scoreboard;
    esc_state_t         esc;
    logic [7:0]         held_digit;
    logic [7:0]         run_q[$];      // bytes produced by the current input beat
    ufd_pkg::out_beat_t expected_q[$];
    int                 errors;

    function new();
      esc        = ESC_NONE;
      held_digit = 8'h00;
      errors     = 0;
    endfunction

    // Appends one byte to the current input's run.
    function void add_byte(logic [7:0] c);
      run_q = {run_q, c};
    endfunction

    // Plain-text handling: '+' -> space, '%' opens an escape, rest passes.
    function void take_plain(logic [7:0] c);
      if (c == CH_PLUS) begin
        add_byte(CH_SPACE);
      end else if (c == CH_PCT) begin
        esc = ESC_PCT;
      end else begin
        add_byte(c);
      end
    endfunction

    function void note_input(ufd_pkg::in_beat_t b);
      esc_state_t         was;
      logic [4:0]         lo;
      logic [4:0]         hi;
      logic [7:0]         v;
      ufd_pkg::out_beat_t ob;
      was = esc;
      esc = ESC_NONE;
      run_q.delete();
      case (was)
        ESC_PCT: begin
          lo = hex_nibble(b.char_in);
          if (!lo[4]) begin
            held_digit = b.char_in;
            esc        = ESC_DIGIT;
          end else begin
            add_byte(CH_PCT);
            take_plain(b.char_in);
          end
        end
        ESC_DIGIT: begin
          lo = hex_nibble(b.char_in);
          if (!lo[4]) begin
            hi = hex_nibble(held_digit);
            v  = {hi[3:0], lo[3:0]};
            if (v < CTRL_LIMIT || v == CH_DEL) v = CH_UNDERSCORE;
            add_byte(v);
          end else begin
            add_byte(CH_PCT);
            add_byte(held_digit);
            take_plain(b.char_in);
          end
        end
        default: take_plain(b.char_in);
      endcase
      // End of string flushes whatever escape is still open.
      if (b.string_end) begin
        if (esc == ESC_PCT) begin
          add_byte(CH_PCT);
        end else if (esc == ESC_DIGIT) begin
          add_byte(CH_PCT);
          add_byte(held_digit);
        end
        esc = ESC_NONE;
      end
      foreach (run_q[k]) begin
        ob.char_out    = run_q[k];
        ob.run_last    = (k == run_q.size() - 1);
        ob.string_done = ob.run_last && b.string_end;
        expected_q     = {expected_q, ob};
      end
    endfunction

    function void check_result(ufd_pkg::out_beat_t got);
      ufd_pkg::out_beat_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.char_out !== want.char_out) begin
        $display("%0t: char_out mismatch, expected %h, got %h",
                 $time, want.char_out, got.char_out);
        errors++;
      end
      if (got.run_last !== want.run_last) begin
        $display("%0t: run_last mismatch, expected %b, got %b",
                 $time, want.run_last, got.run_last);
        errors++;
      end
      if (got.string_done !== want.string_done) begin
        $display("%0t: string_done mismatch, expected %b, got %b",
                 $time, want.string_done, got.string_done);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  ufd_pkg::in_beat_t  in_beat = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ufd_pkg::out_beat_t out_beat;

  int unsigned src_idle_pct   = 0;   // chance per beat slot that the sender holds off
  int unsigned sink_stall_pct = 0;   // chance per cycle that the sink stalls
  int unsigned beats_sent     = 0;

  decode_scoreboard sb = new();

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  url_percent_decoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  // Sink back-pressure: one fresh draw per cycle, never depends on out_valid.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Monitor. Everything here reads values as they stood at the edge, so input
  // beats are noted before any output beat of the same edge is checked; the queue
  // and output register lie between, so no output belongs to a same-edge input.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(in_beat);
      if (out_valid && !out_stall) sb.check_result(out_beat);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks
  // --------------------------------------------------------------------------

  // Drive one beat and hold it until accepted. Idle slots go first, each with
  // valid low and junk on the payload; a beat drawn with no idle slot after an
  // accepted one is raised in the very next cycle: valid stays high back to back.
  task automatic send_beat(input logic [7:0] c, input logic last_char);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      in_beat  <= '{char_in: 8'($urandom), string_end: 1'($urandom)};
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{char_in: c, string_end: last_char};
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    beats_sent++;
  endtask

  function automatic logic [7:0] rand_hex();
    case ($urandom_range(0, 2))
      0:       return CH_ZERO + 8'($urandom_range(0, 9));
      1:       return CH_UPPER_A + 8'($urandom_range(0, 5));
      default: return CH_LOWER_A + 8'($urandom_range(0, 5));
    endcase
  endfunction

  // One encoded string. Mostly well-formed tokens (plain bytes, '+', proper
  // escapes) with some broken escapes; a quarter get cut short so the end
  // flag can land on a pending escape. One in ten is raw noise with random ends.
  task automatic send_string();
    logic [7:0] text[$];
    int unsigned n_tok;
    int unsigned pick;
    int unsigned cut;
    if ($urandom_range(0, 9) == 0) begin
      n_tok = $urandom_range(1, 8);
      repeat (n_tok) send_beat(8'($urandom), 1'($urandom));
      return;
    end
    n_tok = $urandom_range(1, 6);
    repeat (n_tok) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        text = {text, 8'($urandom)};
      end else if (pick < 50) begin
        text = {text, CH_PLUS};
      end else if (pick < 80) begin
        text = {text, CH_PCT, rand_hex(), rand_hex()};
      end else if (pick < 92) begin
        // escape with arbitrary digits, usually invalid
        text = {text, CH_PCT, 8'($urandom), 8'($urandom)};
      end else begin
        text = {text, CH_PCT};
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(0, text.size() - 1);
      text = text[0:cut];
    end
    foreach (text[i]) send_beat(text[i], i == text.size() - 1);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: byte extremes, '+', escapes in both cases, control-code and
    // DEL masking, the 0x20 boundary, bad first digit, '%' as a bad first
    // digit, and an end flag with a pending escape (three beats out).
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(CH_PLUS, 1'b0);
    send_beat(CH_PCT, 1'b0); send_beat("4", 1'b0); send_beat("1", 1'b0);
    send_beat(CH_PCT, 1'b0); send_beat("7", 1'b0); send_beat("f", 1'b0);
    send_beat(CH_PCT, 1'b0); send_beat("1", 1'b0); send_beat("F", 1'b0);
    send_beat(CH_PCT, 1'b0); send_beat("f", 1'b0); send_beat("F", 1'b0);
    send_beat(CH_PCT, 1'b0); send_beat("G", 1'b0);
    send_beat(CH_PCT, 1'b0); send_beat("a", 1'b0); send_beat(CH_PCT, 1'b1);
    send_beat(CH_PCT, 1'b0); send_beat(CH_PCT, 1'b0);
    send_beat("2", 1'b0); send_beat("0", 1'b0); send_beat("x", 1'b1);

    // Random strings under four idle mixes; the scoreboard carries its state
    // across phases, so no drain is needed between them.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 64; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 64; end
        default: begin src_idle_pct = 32; sink_stall_pct = 32; end
      endcase
      beats_sent = 0;
      while (beats_sent < BEATS_PER_PHASE) send_string();
    end
    in_valid <= 1'b0;

    // Drain, then watch a little longer for stray output.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("%0t: timeout, %0d beats still expected", $time, sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ufd_pkg.sv
rtl/ufd_front.sv
rtl/ufd_fifo.sv
rtl/ufd_back.sv
rtl/url_percent_decoder_top.sv
verif/tb_url_percent_decoder_top.sv
